/* rtl/rop_pkg.sv */
// shared widths, register indexes, pixel codes and result word type
// for the region outer perimeter mark unit; no dependencies
package rop_pkg;

	localparam int CLASS_W    = 2;
	localparam int ROWS_W     = 13;
	localparam int COLS_W     = 11;
	localparam int OUT_ROW_W  = 12;
	localparam int OUT_COL_W  = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam int DEF_MAX_COLS = 1024;
	localparam int DEF_MAX_ROWS = 4096;

	localparam int ROWS_RST = 480;
	localparam int COLS_RST = 640;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

	localparam logic [CLASS_W-1:0] CLASS_UNCHECKED = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_FILLED    = 2'd1;

	typedef struct packed {
		logic [OUT_ROW_W-1:0] out_row;
		logic [OUT_COL_W-1:0] out_col;
		logic                 edge_mark;
		logic                 frame_last;
	} res_t;

endpackage

/* rtl/rop_intf.sv */
// valid/ready channel interfaces of the perimeter mark unit: pixel in,
// result out and register write; depends on rop_pkg
interface rop_pix_if;
	logic                        valid;
	logic                        ready;
	logic [rop_pkg::CLASS_W-1:0] pixel_class;

	modport source (output valid, output pixel_class, input ready);
	modport sink (input valid, input pixel_class, output ready);
endinterface

interface rop_res_if;
	logic                          valid;
	logic                          ready;
	logic [rop_pkg::OUT_ROW_W-1:0] out_row;
	logic [rop_pkg::OUT_COL_W-1:0] out_col;
	logic                          edge_mark;
	logic                          frame_last;

	modport source (output valid, output out_row, output out_col, output edge_mark,
		output frame_last, input ready);
	modport sink (input valid, input out_row, input out_col, input edge_mark,
		input frame_last, output ready);
endinterface

interface rop_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rop_pkg::CFG_IDX_W-1:0]  index;
	logic [rop_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/region_outer_perimeter_mark_unit.sv */
// outer perimeter marker over a raster region map, two line stores in memory
// depends on rop_pkg and the channel interfaces in rop_intf.sv
//
//  channel | role | word
//  --------+------+-----------------------------------------------
//  pixel   | in   | pixel_class
//  result  | out  | out_row, out_col, edge_mark, frame_last
//  cfg     | in   | index, data (0 frame_rows, 1 frame_cols)
//
// one pixel per clock while the result queue has room; with more than one row,
// a last-row pixel gives two words, so that row is bounded by the two-entry result queue
// each word passes through the read stage, then the result queue
// line store reads are issued at accept and forwarded from the write of the
// item ahead; no clearing pass after reset, cfg is always ready
// a stalled result queue holds the read stage, which holds the pixel input
module region_outer_perimeter_mark_unit #(
	parameter int MAX_COLS = rop_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = rop_pkg::DEF_MAX_ROWS
) (
	input logic      clk,
	input logic      arst_n,
	rop_pix_if.sink  pixel,
	rop_res_if.source result,
	rop_cfg_if.sink  cfg
);

	localparam int AW = $clog2(MAX_COLS);
	localparam int RST_ROWS = (rop_pkg::ROWS_RST > MAX_ROWS) ? MAX_ROWS : rop_pkg::ROWS_RST;
	localparam int RST_COLS = (rop_pkg::COLS_RST > MAX_COLS) ? MAX_COLS : rop_pkg::COLS_RST;

	typedef struct packed {
		logic has_up;
		logic up2;
		logic row_last;
		logic col_last;
		logic int_left;
		logic int_right;
		logic int_above;
		logic int_here;
	} flags_t;

	// line stores
	logic [rop_pkg::CLASS_W-1:0] prev_mem [MAX_COLS];
	logic                        upper_mem [MAX_COLS];

	logic [rop_pkg::ROWS_W-1:0]  rows_q, row_q;
	logic [rop_pkg::COLS_W-1:0]  cols_q, col_q;
	logic [rop_pkg::CLASS_W-1:0] left_q;

	logic                        s1_valid_q;
	logic [rop_pkg::ROWS_W-1:0]  row_s1;
	logic [rop_pkg::COLS_W-1:0]  col_s1;
	logic [rop_pkg::CLASS_W-1:0] pix_s1;
	flags_t                      fl_s1;
	logic [rop_pkg::CLASS_W-1:0] rd_c_s1, rd_n_s1;
	logic                        rd_u_s1;
	logic                        fwd_c_s1, fwd_n_s1, fwd_u_s1;
	logic [rop_pkg::CLASS_W-1:0] fwd_p_s1;
	logic                        fwd_up_s1;

	rop_pkg::res_t slot_q [2];
	rop_pkg::res_t slot_d [2];
	logic [1:0]    cnt_q, cnt_d, occ;

	logic   in_acc, cfg_acc, pop, s1_adv, fits;
	flags_t fl_d;
	logic [rop_pkg::ROWS_W:0] r_p1, r_p2;
	logic [rop_pkg::COLS_W:0] c_p1, c_p2, c_p3;
	logic [rop_pkg::CLASS_W-1:0] centre, nxt_cls;
	logic   upper_v, hit, upper_wr, mark_b;
	logic [2:0] n_res;
	logic [rop_pkg::ROWS_W-1:0] rows_new;
	logic [rop_pkg::COLS_W-1:0] cols_new;
	rop_pkg::res_t res_a, res_b;
	logic [AW-1:0] waddr;

	assign in_acc  = pixel.valid && pixel.ready;
	assign cfg_acc = cfg.valid && cfg.ready;
	assign cfg.ready = 1'b1;

	// register values clamped into the supported range
	always_comb begin
		rows_new = cfg.data;
		if (cfg.data == '0)
			rows_new = rop_pkg::ROWS_W'(1);
		else if (32'(cfg.data) > MAX_ROWS)
			rows_new = rop_pkg::ROWS_W'(MAX_ROWS);
		cols_new = cfg.data[rop_pkg::COLS_W-1:0];
		if (cfg.data[rop_pkg::COLS_W-1:0] == '0)
			cols_new = rop_pkg::COLS_W'(1);
		else if (32'(cfg.data[rop_pkg::COLS_W-1:0]) > MAX_COLS)
			cols_new = rop_pkg::COLS_W'(MAX_COLS);
	end

	// position flags of the arriving pixel
	always_comb begin
		r_p1 = {1'b0, row_q} + 1'b1;
		r_p2 = {1'b0, row_q} + 2'd2;
		c_p1 = {1'b0, col_q} + 1'b1;
		c_p2 = {1'b0, col_q} + 2'd2;
		c_p3 = {1'b0, col_q} + 2'd3;
		fl_d.has_up    = row_q != '0;
		fl_d.up2       = row_q >= rop_pkg::ROWS_W'(2);
		fl_d.row_last  = r_p1 == {1'b0, rows_q};
		fl_d.col_last  = c_p1 == {1'b0, cols_q};
		fl_d.int_left  = fl_d.up2 && r_p1 <= {1'b0, rows_q}
			&& col_q >= rop_pkg::COLS_W'(2) && c_p1 <= {1'b0, cols_q};
		fl_d.int_right = fl_d.up2 && r_p1 <= {1'b0, rows_q} && c_p3 <= {1'b0, cols_q};
		fl_d.int_above = fl_d.up2 && r_p1 <= {1'b0, rows_q}
			&& col_q != '0 && c_p2 <= {1'b0, cols_q};
		fl_d.int_here  = fl_d.has_up && r_p2 <= {1'b0, rows_q}
			&& col_q != '0 && c_p2 <= {1'b0, cols_q};
	end

	// read stage: merge forwarded write data and build the words
	always_comb begin
		centre  = fwd_c_s1 ? fwd_p_s1 : rd_c_s1;
		nxt_cls = fwd_n_s1 ? fwd_p_s1 : rd_n_s1;
		upper_v = fwd_u_s1 ? fwd_up_s1 : rd_u_s1;
		hit = (fl_s1.up2 && upper_v)
			|| (left_q == rop_pkg::CLASS_FILLED && fl_s1.int_left)
			|| (nxt_cls == rop_pkg::CLASS_FILLED && fl_s1.int_right)
			|| (pix_s1 == rop_pkg::CLASS_FILLED && fl_s1.int_here);
		upper_wr = centre == rop_pkg::CLASS_FILLED && fl_s1.int_above;
		mark_b = pix_s1 == rop_pkg::CLASS_UNCHECKED && fl_s1.has_up
			&& centre == rop_pkg::CLASS_FILLED && fl_s1.int_above;
		res_a.out_row    = rop_pkg::OUT_ROW_W'(row_s1 - 1'b1);
		res_a.out_col    = rop_pkg::OUT_COL_W'(col_s1);
		res_a.edge_mark  = centre == rop_pkg::CLASS_UNCHECKED && hit;
		res_a.frame_last = 1'b0;
		res_b.out_row    = rop_pkg::OUT_ROW_W'(row_s1);
		res_b.out_col    = rop_pkg::OUT_COL_W'(col_s1);
		res_b.edge_mark  = mark_b;
		res_b.frame_last = fl_s1.col_last;
		waddr = AW'(col_s1);
	end

	// result queue admission
	assign pop    = result.valid && result.ready;
	assign occ    = cnt_q - {1'b0, pop};
	assign n_res  = {2'b0, fl_s1.has_up} + {2'b0, fl_s1.row_last};
	assign fits   = ({1'b0, occ} + n_res) <= 3'd2;
	assign s1_adv = s1_valid_q && fits;
	assign pixel.ready = !s1_valid_q || s1_adv;

	always_comb begin
		slot_d = slot_q;
		cnt_d  = occ;
		if (pop)
			slot_d[0] = slot_q[1];
		if (s1_adv) begin
			if (fl_s1.has_up) begin
				slot_d[occ[0]] = res_a;
				if (fl_s1.row_last)
					slot_d[1] = res_b;
			end else if (fl_s1.row_last) begin
				slot_d[occ[0]] = res_b;
			end
			cnt_d = occ + n_res[1:0];
		end
	end

	assign result.valid      = cnt_q != '0;
	assign result.out_row    = slot_q[0].out_row;
	assign result.out_col    = slot_q[0].out_col;
	assign result.edge_mark  = slot_q[0].edge_mark;
	assign result.frame_last = slot_q[0].frame_last;

	// line store memories: reads at accept, write-back when the read stage moves
	always_ff @(posedge clk) begin
		if (s1_adv)
			prev_mem[waddr] <= pix_s1;
		if (in_acc) begin
			rd_c_s1 <= prev_mem[AW'(col_q)];
			rd_n_s1 <= prev_mem[AW'(c_p1)];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && fl_s1.has_up)
			upper_mem[waddr] <= upper_wr;
		if (in_acc)
			rd_u_s1 <= upper_mem[AW'(col_q)];
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_s1    <= row_q;
			col_s1    <= col_q;
			pix_s1    <= pixel.pixel_class;
			fl_s1     <= fl_d;
			fwd_p_s1  <= pix_s1;
			fwd_up_s1 <= upper_wr;
		end
		slot_q <= slot_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= rop_pkg::ROWS_W'(RST_ROWS);
			cols_q     <= rop_pkg::COLS_W'(RST_COLS);
			row_q      <= '0;
			col_q      <= '0;
			left_q     <= '0;
			s1_valid_q <= 1'b0;
			fwd_c_s1   <= 1'b0;
			fwd_n_s1   <= 1'b0;
			fwd_u_s1   <= 1'b0;
			cnt_q      <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (in_acc)
				s1_valid_q <= 1'b1;
			else if (s1_adv)
				s1_valid_q <= 1'b0;
			if (in_acc) begin
				// centre or next column written by the item ahead in this very edge
				fwd_c_s1 <= s1_adv && col_s1 == col_q;
				fwd_n_s1 <= s1_adv && {1'b0, col_s1} == c_p1;
				fwd_u_s1 <= s1_adv && fl_s1.has_up && col_s1 == col_q;
				if (fl_d.col_last) begin
					col_q <= '0;
					row_q <= fl_d.row_last ? '0 : r_p1[rop_pkg::ROWS_W-1:0];
				end else begin
					col_q <= c_p1[rop_pkg::COLS_W-1:0];
				end
			end
			if (s1_adv && fl_s1.has_up)
				left_q <= centre;
			if (cfg_acc) begin
				unique case (cfg.index)
					rop_pkg::REG_FRAME_ROWS: begin
						rows_q <= rows_new;
						row_q  <= '0;
						col_q  <= '0;
						left_q <= '0;
					end
					rop_pkg::REG_FRAME_COLS: begin
						cols_q <= cols_new;
						row_q  <= '0;
						col_q  <= '0;
						left_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < rows_q && col_q < cols_q)
		else $error("input position outside the frame");

	a_fwd_centre: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s1_adv && col_s1 == col_q) |=> centre == $past(pix_s1))
		else $error("centre pixel not forwarded from the write ahead");

	a_queue_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue overfilled");

endmodule

/* tb/region_outer_perimeter_mark_unit_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for region_outer_perimeter_mark_unit: raster pixel words in,
// perimeter mark words checked against an in-bench line-store predictor
// depends on rop_pkg and the channel interfaces in rop_intf.sv
module region_outer_perimeter_mark_unit_tb;

	localparam int LINE_DEPTH   = rop_pkg::DEF_MAX_COLS;
	localparam int ROW_LIMIT    = rop_pkg::DEF_MAX_ROWS;
	localparam int SETTLE_CYCLES = 4;

	localparam logic [rop_pkg::CLASS_W-1:0] CLASS_CHECKED = 2'd2;
	localparam logic [rop_pkg::CLASS_W-1:0] CLASS_SPARE   = 2'd3;

	localparam logic [rop_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
	localparam logic [rop_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	rop_pix_if pix_if ();
	rop_res_if res_if ();
	rop_cfg_if cfg_if ();

	region_outer_perimeter_mark_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [rop_pkg::ROWS_W-1:0]  frame_rows_reg;
	logic [rop_pkg::COLS_W-1:0]  frame_cols_reg;
	int                          cur_row;
	int                          cur_col;
	logic [rop_pkg::CLASS_W-1:0] prev_line [LINE_DEPTH];
	bit                          upper_line [LINE_DEPTH];
	logic [rop_pkg::CLASS_W-1:0] left_class;

	rop_pkg::res_t pending_marks [$];

	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int hold_left = 0;

	int error_count;
	int pixels_sent;
	int words_seen = 0;
	int marks_seen = 0;
	int writes_done;

	task automatic report_mismatch(input string what);
		error_count++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	task automatic add_expected(input rop_pkg::res_t w);
		pending_marks.insert(pending_marks.size(), w);
	endtask

	function automatic int active_rows();
		if (frame_rows_reg == 0) return 1;
		if (frame_rows_reg > ROW_LIMIT) return ROW_LIMIT;
		return int'(frame_rows_reg);
	endfunction

	function automatic int active_cols();
		if (frame_cols_reg == 0) return 1;
		if (frame_cols_reg > LINE_DEPTH) return LINE_DEPTH;
		return int'(frame_cols_reg);
	endfunction

	function automatic bit is_interior(input int r, input int c, input int nr, input int nc);
		return r >= 1 && r + 2 <= nr && c >= 1 && c + 2 <= nc;
	endfunction

	// one accepted pixel: emit row above (if any), then the pixel itself on the last row
	task automatic predict_marks(input logic [rop_pkg::CLASS_W-1:0] cls);
		int nr;
		int nc;
		int r;
		int c;
		logic [rop_pkg::CLASS_W-1:0] centre;
		bit hit;
		rop_pkg::res_t word;
		nr = active_rows();
		nc = active_cols();
		r = cur_row;
		c = cur_col;
		if (r >= 1) begin
			centre = prev_line[c];
			hit = (r >= 2) && upper_line[c];
			if (c >= 1 && left_class == rop_pkg::CLASS_FILLED
					&& is_interior(r - 1, c - 1, nr, nc))
				hit = 1'b1;
			if (c + 1 < nc && prev_line[c + 1] == rop_pkg::CLASS_FILLED
					&& is_interior(r - 1, c + 1, nr, nc))
				hit = 1'b1;
			if (cls == rop_pkg::CLASS_FILLED && is_interior(r, c, nr, nc))
				hit = 1'b1;
			word.out_row = rop_pkg::OUT_ROW_W'(r - 1);
			word.out_col = rop_pkg::OUT_COL_W'(c);
			word.edge_mark = (centre == rop_pkg::CLASS_UNCHECKED) && hit;
			word.frame_last = 1'b0;
			add_expected(word);
			upper_line[c] = (centre == rop_pkg::CLASS_FILLED) && is_interior(r - 1, c, nr, nc);
			left_class = centre;
		end
		if (r + 1 == nr) begin
			word.out_row = rop_pkg::OUT_ROW_W'(r);
			word.out_col = rop_pkg::OUT_COL_W'(c);
			word.edge_mark = cls == rop_pkg::CLASS_UNCHECKED && r >= 1
				&& prev_line[c] == rop_pkg::CLASS_FILLED && is_interior(r - 1, c, nr, nc);
			word.frame_last = (c + 1 == nc);
			add_expected(word);
		end
		prev_line[c] = cls;
		c++;
		if (c >= nc) begin
			c = 0;
			r++;
			if (r >= nr)
				r = 0;
		end
		cur_row = r;
		cur_col = c;
	endtask

	function automatic logic [rop_pkg::CLASS_W-1:0] random_class(input int fill_pct);
		int roll;
		roll = $urandom_range(99);
		if (roll < fill_pct) return rop_pkg::CLASS_FILLED;
		if (roll < fill_pct + (100 - fill_pct) * 2 / 3) return rop_pkg::CLASS_UNCHECKED;
		if (roll < 97) return CLASS_CHECKED;
		return CLASS_SPARE;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance with valid still high
	task automatic send_pixel(input logic [rop_pkg::CLASS_W-1:0] cls);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_if.valid <= 1'b0;
			@(negedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.pixel_class <= cls;
		do @(posedge clk); while (!pix_if.ready);
		predict_marks(cls);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic stream_pixels(input int count, input int fill_pct);
		for (int i = 0; i < count; i++)
			send_pixel(random_class(fill_pct));
	endtask

	// drop the pixel valid and wait for every expected word, then let the pipe settle
	task automatic wait_results_drained();
		pix_if.valid <= 1'b0;
		while (pending_marks.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [rop_pkg::CFG_IDX_W-1:0] idx,
			input logic [rop_pkg::CFG_DATA_W-1:0] value);
		wait_results_drained();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		writes_done++;
		if (idx == rop_pkg::REG_FRAME_ROWS)
			frame_rows_reg = value[rop_pkg::ROWS_W-1:0];
		else if (idx == rop_pkg::REG_FRAME_COLS)
			frame_cols_reg = value[rop_pkg::COLS_W-1:0];
		else
			return;
		// any real register write starts a new frame; line stores keep their contents
		cur_row = 0;
		cur_col = 0;
		left_class = rop_pkg::CLASS_UNCHECKED;
	endtask

	task automatic set_frame(input int rows, input int cols);
		write_register(rop_pkg::REG_FRAME_ROWS, rop_pkg::CFG_DATA_W'(rows));
		write_register(rop_pkg::REG_FRAME_COLS, rop_pkg::CFG_DATA_W'(cols));
	endtask

	// receiver: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_words
		rop_pkg::res_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			words_seen++;
			if (res_if.edge_mark === 1'b1)
				marks_seen++;
			if (pending_marks.size() == 0) begin
				report_mismatch($sformatf("word with nothing expected: row %0d col %0d",
					res_if.out_row, res_if.out_col));
			end else begin
				want = pending_marks.pop_front();
				if (res_if.out_row !== want.out_row)
					report_mismatch($sformatf("out_row got %0d want %0d (col %0d)",
						res_if.out_row, want.out_row, want.out_col));
				if (res_if.out_col !== want.out_col)
					report_mismatch($sformatf("out_col got %0d want %0d (row %0d)",
						res_if.out_col, want.out_col, want.out_row));
				if (res_if.edge_mark !== want.edge_mark)
					report_mismatch($sformatf("edge_mark got %b want %b at row %0d col %0d",
						res_if.edge_mark, want.edge_mark, want.out_row, want.out_col));
				if (res_if.frame_last !== want.frame_last)
					report_mismatch($sformatf("frame_last got %b want %b at row %0d col %0d",
						res_if.frame_last, want.frame_last, want.out_row, want.out_col));
			end
		end
	end

	// default frame size straight out of reset: first row plus a bit of the second
	task automatic test_reset_defaults();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		stream_pixels(rop_pkg::COLS_RST + 16, 40);
	endtask

	// hand-built small frames: 3x3 with one interior pixel, then 4x4; border fills must not count
	task automatic test_small_frames();
		logic [rop_pkg::CLASS_W-1:0] three [9];
		logic [rop_pkg::CLASS_W-1:0] four [16];
		three = '{CLASS_SPARE, rop_pkg::CLASS_UNCHECKED, rop_pkg::CLASS_UNCHECKED,
			rop_pkg::CLASS_UNCHECKED, rop_pkg::CLASS_FILLED, rop_pkg::CLASS_UNCHECKED,
			rop_pkg::CLASS_UNCHECKED, rop_pkg::CLASS_UNCHECKED, CLASS_CHECKED};
		four = '{rop_pkg::CLASS_FILLED, rop_pkg::CLASS_UNCHECKED,
			rop_pkg::CLASS_UNCHECKED, rop_pkg::CLASS_FILLED,
			rop_pkg::CLASS_UNCHECKED, rop_pkg::CLASS_FILLED,
			CLASS_CHECKED, rop_pkg::CLASS_UNCHECKED,
			rop_pkg::CLASS_UNCHECKED, rop_pkg::CLASS_UNCHECKED,
			rop_pkg::CLASS_FILLED, rop_pkg::CLASS_UNCHECKED,
			CLASS_SPARE, rop_pkg::CLASS_UNCHECKED,
			rop_pkg::CLASS_UNCHECKED, rop_pkg::CLASS_FILLED};
		send_idle_pct = 20;
		recv_stall_pct = 20;
		set_frame(3, 3);
		foreach (three[i])
			send_pixel(three[i]);
		set_frame(4, 4);
		foreach (four[i])
			send_pixel(four[i]);
	endtask

	// register extremes, masked data bits, ignored indexes and frame wrap
	task automatic test_register_extremes();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_frame(0, 0);
		stream_pixels(3, 50);
		write_register(rop_pkg::REG_FRAME_ROWS, 13'd2);
		write_register(rop_pkg::REG_FRAME_COLS, 13'h1803);
		stream_pixels(8, 50);
		set_frame(5, 4);
		stream_pixels(9, 50);
		write_register(REG_UNUSED_A, 13'h1fff);
		stream_pixels(6, 50);
		write_register(REG_UNUSED_B, 13'h0000);
		stream_pixels(5, 50);
		// single row, columns clipped to the line depth
		set_frame(1, 2047);
		stream_pixels(24, 40);
		// rows clipped to the row limit, one column
		set_frame(8191, 1);
		stream_pixels(12, 40);
		set_frame(3, 24);
		stream_pixels(3 * 24, 35);
		set_frame(ROW_LIMIT, 2);
		stream_pixels(20, 50);
	endtask

	// long receiver hold while the sender keeps pushing, then a mid-frame pause
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_frame(5, 8);
		hold_request = 200;
		stream_pixels(60, 35);
		stream_pixels(17, 35);
		wait_results_drained();
		stream_pixels(30, 35);
		recv_stall_pct = 50;
		hold_request = 100;
		stream_pixels(60, 35);
	endtask

	task automatic test_random_frames(input int idle_pct, input int stall_pct, input int target);
		int start;
		int roll;
		int rows;
		int cols;
		int total;
		int count;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		start = pixels_sent;
		while (pixels_sent - start < target) begin
			roll = $urandom_range(99);
			if (roll < 5) rows = 0;
			else if (roll < 9) rows = $urandom_range(ROW_LIMIT + 1, 8191);
			else if (roll < 15) rows = 1;
			else rows = $urandom_range(2, 9);
			roll = $urandom_range(99);
			if (roll < 5) cols = 0;
			else if (roll < 9) cols = $urandom_range(LINE_DEPTH + 1, 2047);
			else if (roll < 15) cols = 1;
			else cols = $urandom_range(2, 12);
			roll = $urandom_range(99);
			if (roll < 15) begin
				write_register(rop_pkg::REG_FRAME_ROWS, rop_pkg::CFG_DATA_W'(rows));
			end else if (roll < 30) begin
				write_register(rop_pkg::REG_FRAME_COLS, rop_pkg::CFG_DATA_W'(cols));
			end else if (roll < 65) begin
				set_frame(rows, cols);
			end else begin
				write_register(rop_pkg::REG_FRAME_COLS, rop_pkg::CFG_DATA_W'(cols));
				write_register(rop_pkg::REG_FRAME_ROWS, rop_pkg::CFG_DATA_W'(rows));
			end
			total = active_rows() * active_cols();
			if (total > 150)
				count = $urandom_range(20, 150);
			else
				count = total * $urandom_range(1, 2);
			// some frames are cut short by the next register write
			if ($urandom_range(99) < 20)
				count = $urandom_range(1, count);
			stream_pixels(count, $urandom_range(10, 60));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		pix_if.valid = 1'b0;
		pix_if.pixel_class = rop_pkg::CLASS_UNCHECKED;
		cfg_if.valid = 1'b0;
		cfg_if.index = rop_pkg::REG_FRAME_ROWS;
		cfg_if.data = '0;
		frame_rows_reg = rop_pkg::ROWS_RST;
		frame_cols_reg = rop_pkg::COLS_RST;
		cur_row = 0;
		cur_col = 0;
		left_class = rop_pkg::CLASS_UNCHECKED;
		foreach (prev_line[i])
			prev_line[i] = rop_pkg::CLASS_UNCHECKED;
		foreach (upper_line[i])
			upper_line[i] = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		error_count = 0;
		pixels_sent = 0;
		writes_done = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_small_frames();
		test_register_extremes();
		test_backpressure();
		test_random_frames(0, 0, 110);
		test_random_frames(69, 0, 110);
		test_random_frames(0, 69, 110);
		test_random_frames(38, 38, 110);

		pix_if.valid <= 1'b0;
		for (int i = 0; i < 20000 && pending_marks.size() != 0; i++)
			@(negedge clk);
		repeat (SETTLE_CYCLES * 4) @(negedge clk);
		if (pending_marks.size() != 0)
			report_mismatch($sformatf("%0d expected words never arrived", pending_marks.size()));

		$display("covered %0d pixels and %0d register writes over directed, extreme %s",
			pixels_sent, writes_done, "and random frames");
		$display("checked %0d result words, %0d of them marked, %0d mismatches",
			words_seen, marks_seen, error_count);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
